@@ src/bprfp_pkg.sv @@
// Shared types, byte codes and helpers for the blood-pressure result frame parser.
`default_nettype none
package bprfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned OutW   = 88;
  localparam int unsigned TermW  = 14;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_SEP = 8'h3B;
  localparam logic [7:0] TAG_S    = 8'h53;
  localparam logic [7:0] TAG_A    = 8'h41;
  localparam logic [7:0] TAG_C    = 8'h43;
  localparam logic [7:0] TAG_M    = 8'h4D;
  localparam logic [7:0] TAG_P    = 8'h50;
  localparam logic [7:0] TAG_R    = 8'h52;
  localparam logic [7:0] TAG_T    = 8'h54;
  localparam logic [7:0] ASCII_0  = 8'h30;

  localparam logic [9:0] W_1    = 10'd1;
  localparam logic [9:0] W_10   = 10'd10;
  localparam logic [9:0] W_100  = 10'd100;
  localparam logic [9:0] W_1000 = 10'd1000;

  typedef enum logic [5:0] {
    POS_S_TAG   = 6'd0,
    POS_S_D0    = 6'd1,
    POS_S_SEP   = 6'd2,
    POS_A_TAG   = 6'd3,
    POS_A_D0    = 6'd4,
    POS_A_SEP   = 6'd5,
    POS_C_TAG   = 6'd6,
    POS_C_D1    = 6'd7,
    POS_C_D0    = 6'd8,
    POS_C_SEP   = 6'd9,
    POS_M_TAG   = 6'd10,
    POS_M_D1    = 6'd11,
    POS_M_D0    = 6'd12,
    POS_M_SEP   = 6'd13,
    POS_P_TAG   = 6'd14,
    POS_SYS_D2  = 6'd15,
    POS_SYS_D1  = 6'd16,
    POS_SYS_D0  = 6'd17,
    POS_DIA_D2  = 6'd18,
    POS_DIA_D1  = 6'd19,
    POS_DIA_D0  = 6'd20,
    POS_MEAN_D2 = 6'd21,
    POS_MEAN_D1 = 6'd22,
    POS_MEAN_D0 = 6'd23,
    POS_P_SEP   = 6'd24,
    POS_R_TAG   = 6'd25,
    POS_R_D2    = 6'd26,
    POS_R_D1    = 6'd27,
    POS_R_D0    = 6'd28,
    POS_R_SEP   = 6'd29,
    POS_T_TAG   = 6'd30,
    POS_T_D3    = 6'd31,
    POS_T_D2    = 6'd32,
    POS_T_D1    = 6'd33,
    POS_T_D0    = 6'd34,
    POS_DONE    = 6'd35,
    POS_IDLE    = 6'd63
  } pos_t;

  typedef struct packed {
    logic [13:0] elapsed_time;
    logic [9:0]  pulse_bpm;
    logic [9:0]  mean_mmhg;
    logic [9:0]  diastolic_mmhg;
    logic [9:0]  systolic_mmhg;
    logic [7:0]  message_code;
    logic [7:0]  cycle_mode;
    logic [7:0]  measure_mode;
    logic [7:0]  status_code;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } byte_in_t;

  // (byte - '0') * weight, modulo 2^14; narrower fields take the low bits
  function automatic logic [TermW-1:0] digit_term(input logic [7:0] b,
                                                  input logic [9:0] weight);
    logic [TermW-1:0] d;
    d = {6'd0, b} - {6'd0, ASCII_0};
    return TermW'(d * {4'd0, weight});
  endfunction

endpackage
`default_nettype wire

@@ src/bprfp_parse_core.sv @@
// Frame position tracking and field accumulation for the result frame parser.
`default_nettype none
module bprfp_parse_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire bprfp_pkg::byte_in_t byte_in,
  output logic                     emit,
  output bprfp_pkg::result_t       fields
);
  import bprfp_pkg::*;

  pos_t        pos_r, pos_nxt;
  logic        seen_r, seen_nxt;
  result_t     fld_r, fld_nxt;
  logic [7:0]  b;
  logic        step;

  assign b     = byte_in.rx_byte;
  assign step  = byte_in.valid;
  assign emit  = step && seen_r && (b == BYTE_CR);
  assign fields = fld_r;

  // next position
  always_comb begin
    pos_nxt = pos_r;
    if (emit) begin
      pos_nxt = POS_IDLE;
    end else if (step) begin
      unique case (pos_r)
        POS_S_TAG:   if (b == TAG_S) pos_nxt = POS_S_D0;
        POS_S_SEP, POS_A_SEP, POS_C_SEP, POS_M_SEP, POS_P_SEP, POS_R_SEP:
          if (b == BYTE_SEP) pos_nxt = pos_t'(pos_r + 6'd1);
        POS_A_TAG:   if (b == TAG_A) pos_nxt = POS_A_D0;
        POS_C_TAG:   if (b == TAG_C) pos_nxt = POS_C_D1;
        POS_M_TAG:   if (b == TAG_M) pos_nxt = POS_M_D1;
        POS_P_TAG:   if (b == TAG_P) pos_nxt = POS_SYS_D2;
        POS_R_TAG:   if (b == TAG_R) pos_nxt = POS_R_D2;
        POS_T_TAG:   if (b == TAG_T) pos_nxt = POS_T_D3;
        POS_S_D0, POS_A_D0, POS_C_D1, POS_C_D0, POS_M_D1, POS_M_D0,
        POS_SYS_D2, POS_SYS_D1, POS_SYS_D0, POS_DIA_D2, POS_DIA_D1, POS_DIA_D0,
        POS_MEAN_D2, POS_MEAN_D1, POS_MEAN_D0, POS_R_D2, POS_R_D1, POS_R_D0,
        POS_T_D3, POS_T_D2, POS_T_D1:
          pos_nxt = pos_t'(pos_r + 6'd1);
        POS_T_D0:    pos_nxt = POS_DONE;
        default:     pos_nxt = pos_r;
      endcase
      // frame control bytes override whatever the position did
      if (b == BYTE_STX) begin
        pos_nxt = POS_S_TAG;
      end else if (b == BYTE_ETX) begin
        pos_nxt = POS_IDLE;
      end
    end
  end

  // field updates
  always_comb begin
    fld_nxt  = fld_r;
    seen_nxt = seen_r;
    if (emit) begin
      seen_nxt = 1'b0;
    end else if (step) begin
      unique case (pos_r)
        POS_S_TAG:   if (b == TAG_S) seen_nxt = 1'b1;
        POS_S_D0:    fld_nxt.status_code  = 8'(digit_term(b, W_1));
        POS_A_D0:    fld_nxt.measure_mode = 8'(digit_term(b, W_1));
        POS_C_D1:    fld_nxt.cycle_mode   = 8'(digit_term(b, W_10));
        POS_C_D0:    fld_nxt.cycle_mode   = fld_r.cycle_mode + 8'(digit_term(b, W_1));
        POS_M_D1:    fld_nxt.message_code = 8'(digit_term(b, W_10));
        POS_M_D0:    fld_nxt.message_code = fld_r.message_code + 8'(digit_term(b, W_1));
        POS_SYS_D2:  fld_nxt.systolic_mmhg = 10'(digit_term(b, W_100));
        POS_SYS_D1:  fld_nxt.systolic_mmhg = fld_r.systolic_mmhg + 10'(digit_term(b, W_10));
        POS_SYS_D0:  fld_nxt.systolic_mmhg = fld_r.systolic_mmhg + 10'(digit_term(b, W_1));
        POS_DIA_D2:  fld_nxt.diastolic_mmhg = 10'(digit_term(b, W_100));
        POS_DIA_D1:  fld_nxt.diastolic_mmhg = fld_r.diastolic_mmhg + 10'(digit_term(b, W_10));
        POS_DIA_D0:  fld_nxt.diastolic_mmhg = fld_r.diastolic_mmhg + 10'(digit_term(b, W_1));
        POS_MEAN_D2: fld_nxt.mean_mmhg = 10'(digit_term(b, W_100));
        POS_MEAN_D1: fld_nxt.mean_mmhg = fld_r.mean_mmhg + 10'(digit_term(b, W_10));
        POS_MEAN_D0: fld_nxt.mean_mmhg = fld_r.mean_mmhg + 10'(digit_term(b, W_1));
        POS_R_D2:    fld_nxt.pulse_bpm = 10'(digit_term(b, W_100));
        POS_R_D1:    fld_nxt.pulse_bpm = fld_r.pulse_bpm + 10'(digit_term(b, W_10));
        POS_R_D0:    fld_nxt.pulse_bpm = fld_r.pulse_bpm + 10'(digit_term(b, W_1));
        POS_T_D3:    fld_nxt.elapsed_time = digit_term(b, W_1000);
        POS_T_D2:    fld_nxt.elapsed_time = fld_r.elapsed_time + digit_term(b, W_100);
        POS_T_D1:    fld_nxt.elapsed_time = fld_r.elapsed_time + digit_term(b, W_10);
        POS_T_D0:    fld_nxt.elapsed_time = fld_r.elapsed_time + digit_term(b, W_1);
        default:     fld_nxt = fld_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_IDLE;
      seen_r <= 1'b0;
      fld_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      seen_r <= seen_nxt;
      fld_r  <= fld_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/bp_result_frame_parser.sv @@
// Top level of the blood-pressure result frame parser with its result register.
//
// Takes one received byte per item on the in_ stream and accepts a byte in
// every cycle unless a held result stalls: each byte updates the frame position
// and field registers in the cycle it is accepted. A carriage return that
// follows an accepted 'S' tag produces one item on the out_ stream in the next
// cycle, holding all nine measurement fields; every other byte produces nothing.
// The result sits in a single output register, so the input stalls only while a
// result is held and out_tready is low. Fields keep their values across frames.
`default_nettype none
module bp_result_frame_parser (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [bprfp_pkg::ByteW-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // [7:0] status_code, [15:8] measure_mode, [23:16] cycle_mode,
  // [31:24] message_code, [41:32] systolic_mmhg, [51:42] diastolic_mmhg,
  // [61:52] mean_mmhg, [71:62] pulse_bpm, [85:72] elapsed_time, [87:86] zero
  output logic [bprfp_pkg::OutW-1:0]   out_tdata
);
  import bprfp_pkg::*;

  byte_in_t   byte_in;
  logic       emit;
  result_t    fields;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_data_r;

  assign in_tready     = !out_valid_r || out_tready;
  assign byte_in.valid = in_tvalid && in_tready;
  assign byte_in.rx_byte = in_tdata;

  bprfp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_in (byte_in),
    .emit    (emit),
    .fields  (fields)
  );

  // hold the result until taken; refill on a new emitting byte
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= fields;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

endmodule
`default_nettype wire

@@ src/bprfp_checker.sv @@
// Port-level checks for the result frame parser, bound to the top level.
`default_nettype none
module bprfp_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_tvalid,
  input wire                          in_tready,
  input wire  [bprfp_pkg::ByteW-1:0]  in_tdata,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire  [bprfp_pkg::OutW-1:0]   out_tdata
);
  import bprfp_pkg::*;

  // a new result only follows an accepted carriage return
  a_emit_after_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid && !out_tready)) |->
      $past(in_tvalid && in_tready && (in_tdata == BYTE_CR)))
    else $error("result without an accepted carriage return");

  // the input is open whenever no result is held
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // padding bits of a result are zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OutW-1:OutW-2] == 2'b00))
    else $error("nonzero padding in result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule

bind bp_result_frame_parser bprfp_checker u_bprfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
